/* rtl/core/sorted_priority_queue_core_macros.svh */
// Assertion macros for the sorted priority queue core.
// Each check samples on the rising edge of i_clk in the module that uses it.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check that is switched off while reset is held.
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check that holds through reset as well.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define SPQ_ASSERT(label, prop, msg)
`define SPQ_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* rtl/core/spq_pkg.sv */
`default_nettype none

package spq_pkg;

    // Payload widths of one beat.
    localparam int VALUE_W = 32;
    localparam int RANK_W  = 16;
    localparam int OCC_W   = 5;

    // Operation carried by an input beat.
    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } t_kind;

    // Result status of an output beat.
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Shift commands broadcast to every slot.
    typedef struct packed {
        logic shift_in;
        logic shift_out;
    } t_slot_ctrl;

endpackage

`default_nettype wire

/* rtl/core/sorted_priority_queue_core.sv */
// Sorted priority queue core.
// Input channel (i_in_valid / o_in_ready) carries one operation per beat:
// i_kind selects insert or remove, i_item_value and i_item_rank give the
// entry on insert. Output channel (o_out_valid / i_out_ready) returns one
// beat per operation with o_status, the removed entry and o_occupancy.
// Entries are kept in a row of slot registers sorted by descending rank;
// equal ranks leave in arrival order. Every slot compares its rank with the
// incoming one in parallel, and the whole row shifts at once.
// Throughput: one operation per cycle while the receiver keeps up. A beat
// passes from the input register to the result register once that is free.
// When the receiver stalls, the result register holds its beat, the input
// register takes one more beat, and then o_in_ready drops.
// Reset empties the queue and clears both valid flags; slot contents are
// left as they are and are not visible until written.
`default_nettype none

`include "sorted_priority_queue_core_macros.svh"

module sorted_priority_queue_core #(
    parameter int CAPACITY = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire                              i_kind,
    input  wire  signed [spq_pkg::VALUE_W-1:0] i_item_value,
    input  wire  [spq_pkg::RANK_W-1:0]       i_item_rank,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [1:0]                       o_status,
    output logic signed [spq_pkg::VALUE_W-1:0] o_popped_value,
    output logic [spq_pkg::RANK_W-1:0]       o_popped_rank,
    output logic [spq_pkg::OCC_W-1:0]        o_occupancy
);

    localparam int FW      = $clog2(CAPACITY + 1);
    localparam int OccExtW = (FW > spq_pkg::OCC_W) ? FW : spq_pkg::OCC_W;

    // Input register.
    logic                        r_in_valid;
    spq_pkg::t_kind              r_in_kind;
    logic [spq_pkg::VALUE_W-1:0] r_in_value;
    logic [spq_pkg::RANK_W-1:0]  r_in_rank;

    // Result register.
    logic                        r_out_valid;
    spq_pkg::t_status            r_out_status;
    logic [spq_pkg::VALUE_W-1:0] r_out_value;
    logic [spq_pkg::RANK_W-1:0]  r_out_rank;
    logic [spq_pkg::OCC_W-1:0]   r_out_occ;

    // Queue state.
    logic [FW-1:0]               r_fill;
    logic [FW-1:0]               n_fill;

    logic                        w_advance;
    logic                        w_full;
    logic                        w_empty;
    spq_pkg::t_slot_ctrl         w_ctrl;
    spq_pkg::t_status            n_status;
    logic [spq_pkg::VALUE_W-1:0] n_pop_value;
    logic [spq_pkg::RANK_W-1:0]  n_pop_rank;
    logic [OccExtW-1:0]          w_occ_ext;

    logic [spq_pkg::VALUE_W-1:0] w_value [CAPACITY];
    logic [spq_pkg::RANK_W-1:0]  w_rank  [CAPACITY];
    logic                        w_ge    [CAPACITY];

    // The input register moves on whenever the result register is free or being emptied.
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_kind  <= spq_pkg::t_kind'(i_kind);
            r_in_value <= i_item_value;
            r_in_rank  <= i_item_rank;
        end
    end

    // Shift commands for the slot row.
    assign w_full  = (r_fill == FW'(CAPACITY));
    assign w_empty = (r_fill == '0);

    always_comb begin
        w_ctrl.shift_in  = w_advance && (r_in_kind == spq_pkg::KIND_INSERT) && !w_full;
        w_ctrl.shift_out = w_advance && (r_in_kind == spq_pkg::KIND_REMOVE) && !w_empty;
    end

    // Slot row, front at index zero.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_slot
        logic                        w_prev_ge;
        logic [spq_pkg::VALUE_W-1:0] w_prev_value;
        logic [spq_pkg::RANK_W-1:0]  w_prev_rank;
        logic [spq_pkg::VALUE_W-1:0] w_next_value;
        logic [spq_pkg::RANK_W-1:0]  w_next_rank;

        if (k == 0) begin : g_front
            assign w_prev_ge    = 1'b1;
            assign w_prev_value = r_in_value;
            assign w_prev_rank  = r_in_rank;
        end else begin : g_inner
            assign w_prev_ge    = w_ge[k-1];
            assign w_prev_value = w_value[k-1];
            assign w_prev_rank  = w_rank[k-1];
        end

        if (k == CAPACITY - 1) begin : g_back
            assign w_next_value = w_value[k];
            assign w_next_rank  = w_rank[k];
        end else begin : g_body
            assign w_next_value = w_value[k+1];
            assign w_next_rank  = w_rank[k+1];
        end

        spq_slot u_slot (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_in_use     (r_fill > FW'(k)),
            .i_new_value  (r_in_value),
            .i_new_rank   (r_in_rank),
            .i_prev_ge    (w_prev_ge),
            .i_prev_value (w_prev_value),
            .i_prev_rank  (w_prev_rank),
            .i_next_value (w_next_value),
            .i_next_rank  (w_next_rank),
            .o_ge         (w_ge[k]),
            .o_value      (w_value[k]),
            .o_rank       (w_rank[k])
        );
    end

    // Fill level and result of the operation in the input register.
    always_comb begin
        n_fill      = r_fill;
        n_pop_value = '0;
        n_pop_rank  = '0;
        if (w_ctrl.shift_in) begin
            n_fill = r_fill + 1'b1;
        end else if (w_ctrl.shift_out) begin
            n_fill = r_fill - 1'b1;
        end
        if (r_in_kind == spq_pkg::KIND_INSERT) begin
            n_status = w_full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
        end else begin
            n_status = w_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_REMOVED;
            if (!w_empty) begin
                n_pop_value = w_value[0];
                n_pop_rank  = w_rank[0];
            end
        end
    end

    // Occupancy is reported modulo the output width.
    assign w_occ_ext = OccExtW'(n_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // Result register holds its beat until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_status <= n_status;
            r_out_value  <= n_pop_value;
            r_out_rank   <= n_pop_rank;
            r_out_occ    <= w_occ_ext[spq_pkg::OCC_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_popped_value = r_out_value;
    assign o_popped_rank  = r_out_rank;
    assign o_occupancy    = r_out_occ;

    // Checks on the queue state and the result path.
    `SPQ_ASSERT(a_fill_bound, r_fill <= FW'(CAPACITY), "fill level above capacity")
    `SPQ_ASSERT(a_fill_inc, w_ctrl.shift_in |=> (r_fill == $past(r_fill) + 1'b1), "insert lost")
    `SPQ_ASSERT(a_front_sorted, (r_fill >= FW'(2)) |-> (w_rank[0] >= w_rank[1]), "front unsorted")
    `SPQ_ASSERT(a_pop_zero, (o_out_valid && (o_status != spq_pkg::ST_REMOVED)) |-> ((o_popped_value == '0) && (o_popped_rank == '0)), "stray popped entry")

endmodule

`default_nettype wire

/* rtl/core/spq_slot.sv */
`default_nettype none

module spq_slot (
    input  wire                              i_clk,
    input  wire spq_pkg::t_slot_ctrl         i_ctrl,
    input  wire                              i_in_use,
    input  wire  [spq_pkg::VALUE_W-1:0]      i_new_value,
    input  wire  [spq_pkg::RANK_W-1:0]       i_new_rank,
    input  wire                              i_prev_ge,
    input  wire  [spq_pkg::VALUE_W-1:0]      i_prev_value,
    input  wire  [spq_pkg::RANK_W-1:0]       i_prev_rank,
    input  wire  [spq_pkg::VALUE_W-1:0]      i_next_value,
    input  wire  [spq_pkg::RANK_W-1:0]       i_next_rank,
    output logic                             o_ge,
    output logic [spq_pkg::VALUE_W-1:0]      o_value,
    output logic [spq_pkg::RANK_W-1:0]       o_rank
);

    logic [spq_pkg::VALUE_W-1:0] r_value;
    logic [spq_pkg::RANK_W-1:0]  r_rank;
    logic [spq_pkg::VALUE_W-1:0] n_value;
    logic [spq_pkg::RANK_W-1:0]  n_rank;

    // A stored entry ranks ahead of the new one when its priority is not lower.
    assign o_ge    = i_in_use && (r_rank >= i_new_rank);
    assign o_value = r_value;
    assign o_rank  = r_rank;

    // On insert, slots past the insertion point take the neighbor toward the front; on remove, all take the next.
    always_comb begin
        n_value = r_value;
        n_rank  = r_rank;
        if (i_ctrl.shift_in) begin
            if (!o_ge) begin
                if (i_prev_ge) begin
                    n_value = i_new_value;
                    n_rank  = i_new_rank;
                end else begin
                    n_value = i_prev_value;
                    n_rank  = i_prev_rank;
                end
            end
        end else if (i_ctrl.shift_out) begin
            n_value = i_next_value;
            n_rank  = i_next_rank;
        end
    end

    // Entry storage needs no reset; slots past the fill level are never read.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_rank  <= n_rank;
    end

endmodule

`default_nettype wire
